[hdl/gdfs_pkg.sv]
// Shared constants, state encoding and helpers for the graph reachability block.
package gdfs_pkg;

    // Graph size and derived widths
    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int DEPTH_W   = $clog2(MAX_NODES + 1);
    localparam int FIELD_W   = 7;

    // Lowest-bit search splits a row into byte groups
    localparam int GRP_W      = 8;
    localparam int GRP_N      = MAX_NODES / GRP_W;
    localparam int GRP_IDX_W  = $clog2(GRP_W);
    localparam int GRP_SEL_W  = NODE_W - GRP_IDX_W;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_EA_WR  = 10'b00_0000_0010,
        ST_EB_RD  = 10'b00_0000_0100,
        ST_EB_WR  = 10'b00_0000_1000,
        ST_W_INIT = 10'b00_0001_0000,
        ST_W_ROW  = 10'b00_0010_0000,
        ST_W_PICK = 10'b00_0100_0000,
        ST_W_STK  = 10'b00_1000_0000,
        ST_EMIT   = 10'b01_0000_0000,
        ST_CLEAR  = 10'b10_0000_0000
    } state_t;

    // Position of the lowest set bit in one byte group
    function automatic logic [GRP_IDX_W-1:0] lowest_in_grp(input logic [GRP_W-1:0] v);
        logic [GRP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = GRP_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[hdl/graph_reachability_dfs_top.sv]
// Top level: edge loading, depth-first walk from node 1 and per-node result stream.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_node_a, s_node_b, s_last_edge
//  m_      | out       | m_valid / m_ready  | m_node_index, m_seen_flag, m_visited_flag,
//          |           |                    | m_last_result
//
// An edge is a read-modify-write of both rows through the one row memory (row a read,
// row a write, row b read, row b write); an out-of-range edge leaves the rows untouched.
// The walk starts by entering node 1, enters each node with a row read, then a
// lowest-unvisited pick, and backtracks with a pick, stack read and row read (the final
// backtrack ends the walk); then one result per cycle while m_ready is high, then a clear.
// Reset is synchronous, active low; matrix rows carry valid bits, so no clearing pass.
// s_ready is high only between items; a stalled result holds in the output register.
module graph_reachability_dfs_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [gdfs_pkg::FIELD_W-1:0] s_node_a,
    input  logic [gdfs_pkg::FIELD_W-1:0] s_node_b,
    input  logic                        s_last_edge,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [gdfs_pkg::FIELD_W-1:0] m_node_index,
    output logic                        m_seen_flag,
    output logic                        m_visited_flag,
    output logic                        m_last_result
);
    import gdfs_pkg::*;

    state_t                 state_reg, state_next;
    logic [NODE_W-1:0]      ia_reg, ia_next;
    logic [NODE_W-1:0]      ib_reg, ib_next;
    logic                   last_reg, last_next;
    logic [FIELD_W-1:0]     highest_reg, highest_next;
    logic [MAX_NODES-1:0]   row_valid_reg, row_valid_next;
    logic                   row_vld_q_reg;
    logic [MAX_NODES-1:0]   seen_reg, seen_next;
    logic [MAX_NODES-1:0]   visited_reg, visited_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [GRP_N-1:0]       grp_any_reg, grp_any_next;
    logic [GRP_IDX_W-1:0]   grp_idx_reg [GRP_N];
    logic [GRP_IDX_W-1:0]   grp_idx_next [GRP_N];
    logic [NODE_W-1:0]      cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]     m_index_reg, m_index_next;
    logic                   m_seen_reg, m_seen_next;
    logic                   m_visited_reg, m_visited_next;
    logic                   m_last_reg, m_last_next;

    // Memory ports
    logic                   row_we;
    logic [NODE_W-1:0]      row_waddr, row_raddr;
    logic [MAX_NODES-1:0]   row_wdata, row_rdata, row_cur;
    logic                   stk_we;
    logic [NODE_W-1:0]      stk_waddr, stk_raddr;
    logic [NODE_W-1:0]      stk_wdata, stk_rdata;

    // Helpers
    logic                   s_fire;
    logic                   a_ok, b_ok;
    logic [FIELD_W-1:0]     a_m1, b_m1;
    logic [DEPTH_W-1:0]     depth_m2;
    logic [MAX_NODES-1:0]   cand;
    logic                   pick_found;
    logic [GRP_SEL_W-1:0]   pick_grp;
    logic [NODE_W-1:0]      pick_node;
    logic [FIELD_W-1:0]     emit_index;
    logic                   emit_last;
    state_t                 after_edge;

    gdfs_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    gdfs_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign s_fire         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_node_index   = m_index_reg;
    assign m_seen_flag    = m_seen_reg;
    assign m_visited_flag = m_visited_reg;
    assign m_last_result  = m_last_reg;

    // Decode endpoints
    assign a_ok = (s_node_a != '0) && (s_node_a <= FIELD_W'(MAX_NODES));
    assign b_ok = (s_node_b != '0) && (s_node_b <= FIELD_W'(MAX_NODES));
    assign a_m1 = s_node_a - FIELD_W'(1);
    assign b_m1 = s_node_b - FIELD_W'(1);

    // Row read data, invalid rows read as empty
    assign row_cur  = row_vld_q_reg ? row_rdata : '0;
    assign cand     = row_cur & ~visited_reg;
    assign depth_m2 = depth_reg - DEPTH_W'(2);

    // Pick lowest group holding an unvisited neighbour
    always_comb begin
        pick_found = 1'b0;
        pick_grp   = '0;
        for (int g = GRP_N - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                pick_found = 1'b1;
                pick_grp   = GRP_SEL_W'(g);
            end
        end
    end
    assign pick_node = {pick_grp, grp_idx_reg[pick_grp]};

    // Next result fields
    assign emit_index = FIELD_W'(cnt_reg) + FIELD_W'(1);
    assign emit_last  = (emit_index == highest_reg);

    // Where a finished edge goes: back to idle, to the walk, or straight to clear
    assign after_edge = !last_reg            ? ST_IDLE :
                        (highest_reg == '0)  ? ST_CLEAR : ST_W_INIT;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        last_next      = last_reg;
        highest_next   = highest_reg;
        row_valid_next = row_valid_reg;
        seen_next      = seen_reg;
        visited_next   = visited_reg;
        depth_next     = depth_reg;
        grp_any_next   = grp_any_reg;
        grp_idx_next   = grp_idx_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_index_next   = m_index_reg;
        m_seen_next    = m_seen_reg;
        m_visited_next = m_visited_reg;
        m_last_next    = m_last_reg;
        row_we         = 1'b0;
        row_waddr      = ia_reg;
        row_wdata      = row_cur | (MAX_NODES'(1) << ib_reg);
        row_raddr      = ia_reg;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[NODE_W-1:0];
        stk_wdata      = pick_node;
        stk_raddr      = depth_m2[NODE_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                row_raddr = a_m1[NODE_W-1:0];
                if (s_fire) begin
                    ia_next   = a_m1[NODE_W-1:0];
                    ib_next   = b_m1[NODE_W-1:0];
                    last_next = s_last_edge;
                    if (a_ok && b_ok) begin
                        // Track highest node and start row a update
                        if (s_node_a > highest_next) highest_next = s_node_a;
                        if (s_node_b > highest_next) highest_next = s_node_b;
                        state_next = ST_EA_WR;
                    end else if (!s_last_edge) begin
                        state_next = ST_IDLE;
                    end else if (highest_reg == '0) begin
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_W_INIT;
                    end
                end
            end
            ST_EA_WR: begin
                // Set bit b in row a
                row_we                 = 1'b1;
                row_waddr              = ia_reg;
                row_wdata              = row_cur | (MAX_NODES'(1) << ib_reg);
                row_valid_next[ia_reg] = 1'b1;
                state_next             = ST_EB_RD;
            end
            ST_EB_RD: begin
                row_raddr  = ib_reg;
                state_next = ST_EB_WR;
            end
            ST_EB_WR: begin
                // Set bit a in row b
                row_we                 = 1'b1;
                row_waddr              = ib_reg;
                row_wdata              = row_cur | (MAX_NODES'(1) << ia_reg);
                row_valid_next[ib_reg] = 1'b1;
                state_next             = after_edge;
            end
            ST_W_INIT: begin
                // Enter node 1
                seen_next[0]    = 1'b1;
                visited_next[0] = 1'b1;
                stk_we          = 1'b1;
                stk_waddr       = '0;
                stk_wdata       = '0;
                depth_next      = DEPTH_W'(1);
                row_raddr       = '0;
                state_next      = ST_W_ROW;
            end
            ST_W_ROW: begin
                // Mark neighbours seen and scan each byte group
                seen_next = seen_reg | row_cur;
                for (int g = 0; g < GRP_N; g++) begin
                    grp_any_next[g] = |cand[g*GRP_W +: GRP_W];
                    grp_idx_next[g] = lowest_in_grp(cand[g*GRP_W +: GRP_W]);
                end
                state_next = ST_W_PICK;
            end
            ST_W_PICK: begin
                if (pick_found && (depth_reg < DEPTH_W'(MAX_NODES))) begin
                    // Push and enter the neighbour
                    visited_next[pick_node] = 1'b1;
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[NODE_W-1:0];
                    stk_wdata  = pick_node;
                    depth_next = depth_reg + DEPTH_W'(1);
                    row_raddr  = pick_node;
                    state_next = ST_W_ROW;
                end else begin
                    // Backtrack
                    depth_next = depth_reg - DEPTH_W'(1);
                    stk_raddr  = depth_m2[NODE_W-1:0];
                    if (depth_reg == DEPTH_W'(1)) begin
                        cnt_next   = '0;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_W_STK;
                    end
                end
            end
            ST_W_STK: begin
                row_raddr  = stk_rdata;
                state_next = ST_W_ROW;
            end
            ST_EMIT: begin
                // Load one result whenever the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_index_next   = emit_index;
                    m_seen_next    = seen_reg[cnt_reg];
                    m_visited_next = visited_reg[cnt_reg];
                    m_last_next    = emit_last;
                    cnt_next       = cnt_reg + NODE_W'(1);
                    if (emit_last) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                // Drop the graph
                row_valid_next = '0;
                seen_next      = '0;
                visited_next   = '0;
                highest_next   = '0;
                depth_next     = '0;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            highest_reg   <= '0;
            row_valid_reg <= '0;
            row_vld_q_reg <= 1'b0;
            seen_reg      <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            highest_reg   <= highest_next;
            row_valid_reg <= row_valid_next;
            row_vld_q_reg <= row_valid_reg[row_raddr];
            seen_reg      <= seen_next;
            visited_reg   <= visited_next;
            depth_reg     <= depth_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ia_reg        <= ia_next;
        ib_reg        <= ib_next;
        last_reg      <= last_next;
        grp_any_reg   <= grp_any_next;
        grp_idx_reg   <= grp_idx_next;
        m_index_reg   <= m_index_next;
        m_seen_reg    <= m_seen_next;
        m_visited_reg <= m_visited_next;
        m_last_reg    <= m_last_next;
    end

endmodule

[hdl/gdfs_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/gdfs_chk.sv]
// Port-level checker for the graph reachability block, bound to the top level.
module gdfs_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [gdfs_pkg::FIELD_W-1:0] s_node_a,
    input logic [gdfs_pkg::FIELD_W-1:0] s_node_b,
    input logic                        s_last_edge,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [gdfs_pkg::FIELD_W-1:0] m_node_index,
    input logic                        m_seen_flag,
    input logic                        m_visited_flag,
    input logic                        m_last_result
);
    import gdfs_pkg::*;

    logic edge_ok;

    // Both endpoints name a node of the graph
    assign edge_ok = (s_node_a != '0) && (s_node_a <= FIELD_W'(MAX_NODES))
                  && (s_node_b != '0) && (s_node_b <= FIELD_W'(MAX_NODES));

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_node_index) && $stable(m_seen_flag)
            && $stable(m_visited_flag) && $stable(m_last_result))
        else $error("result changed while stalled");

    // Reported node stays within the graph
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_node_index != '0) && (m_node_index <= FIELD_W'(MAX_NODES)))
        else $error("result node out of range");

    // Node 1 is always entered, and entered nodes are seen
    a_start_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_node_index == FIELD_W'(1)) |-> m_seen_flag && m_visited_flag)
        else $error("node 1 not reported visited");

    a_visit_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visited_flag |-> m_seen_flag)
        else $error("visited node not seen");

    // After an in-range edge or a last edge is accepted, s_ready goes low
    a_edge_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (edge_ok || s_last_edge) |=> !s_ready)
        else $error("item accepted on back-to-back cycles");

endmodule

bind graph_reachability_dfs_top gdfs_chk u_gdfs_chk (.*);
